>>> hw/rtl/dlbs_pkg.sv
// ----------------------------------------------------------------------------
// dlbs_pkg
// Shared constants and types of the decimal limb bignum subtractor.
// ----------------------------------------------------------------------------
package dlbs_pkg;

  localparam int MAX_LIMBS = 64;
  localparam int LIMB_W    = 64;
  localparam int IDX_W     = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int CNT_W     = $clog2(MAX_LIMBS + 1);
  localparam int BANKS     = 2;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [LIMB_W-1:0] LIMB_BASE = 64'd10000000000000000000;

  // limb pair write into the operand store
  typedef struct packed {
    logic              we;
    logic              bank;
    logic [IDX_W-1:0]  idx;
    logic [LIMB_W-1:0] a;
    logic [LIMB_W-1:0] b;
  } store_wr_t;

  // one finished operand set, ready for the borrow pass
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] n;
    logic             a_small;
  } job_t;

  typedef struct packed {
    logic busy;
    logic bank;
  } back_stat_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] cnt;
  } jobq_stat_t;

endpackage

>>> hw/rtl/dlbs_front.sv
// ----------------------------------------------------------------------------
// dlbs_front
// Takes limb pairs, writes them to the operand store, decides operand order
// from the top limb down and hands a job to the back end on the final pair.
// ----------------------------------------------------------------------------
module dlbs_front
  import dlbs_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // limb_a [63:0], limb_b [127:64]
  input  logic          in_tlast,   // final_pair
  input  jobq_stat_t    qs,
  input  back_stat_t    bs,
  output store_wr_t     wr,
  output logic          job_push,
  output job_t          job
);

  logic [CNT_W-1:0]  count_r, count_nxt, count_inc;
  logic              decided_r, decided_nxt;
  logic              asm_r, asm_nxt;
  logic              bank_r, bank_nxt;
  logic [QCNT_W:0]   held;
  logic              accept, room;
  logic [LIMB_W-1:0] a, b;

  // banks in use: queued jobs plus the one the back end works on
  assign held      = {1'b0, qs.cnt} + {{QCNT_W{1'b0}}, bs.busy};
  assign in_tready = (held < (QCNT_W+1)'(BANKS));
  assign accept    = in_tvalid & in_tready;
  assign a         = in_tdata[LIMB_W-1:0];
  assign b         = in_tdata[2*LIMB_W-1:LIMB_W];
  assign room      = (count_r < CNT_W'(MAX_LIMBS));

  assign count_inc = count_r + CNT_W'(accept & room);

  always_comb begin
    decided_nxt = decided_r;
    asm_nxt     = asm_r;
    if (accept && room && !decided_r && (a != b)) begin
      decided_nxt = 1'b1;
      asm_nxt     = (a < b);
    end
  end

  assign wr.we   = accept & room;
  assign wr.bank = bank_r;
  assign wr.idx  = count_r[IDX_W-1:0];
  assign wr.a    = a;
  assign wr.b    = b;

  assign job_push    = accept & in_tlast;
  assign job.bank    = bank_r;
  assign job.n       = count_inc;
  assign job.a_small = asm_nxt;

  assign count_nxt = job_push ? '0 : count_inc;
  assign bank_nxt  = job_push ? ~bank_r : bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      decided_r <= 1'b0;
      asm_r     <= 1'b0;
      bank_r    <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      decided_r <= job_push ? 1'b0 : decided_nxt;
      asm_r     <= job_push ? 1'b0 : asm_nxt;
      bank_r    <= bank_nxt;
    end
  end

endmodule

>>> hw/rtl/dlbs_job_q.sv
// ----------------------------------------------------------------------------
// dlbs_job_q
// Short job queue between the loading front end and the subtracting back end.
// ----------------------------------------------------------------------------
module dlbs_job_q
  import dlbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       job_in,
  input  logic       pop,
  output job_t       job_out,
  output jobq_stat_t qs
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign qs.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qs.empty = (cnt_r == '0);
  assign qs.cnt   = cnt_r;

  assign do_push = push & ~qs.full;
  assign do_pop  = pop & ~qs.empty;
  assign job_out = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/dlbs_back.sv
// ----------------------------------------------------------------------------
// dlbs_back
// Holds the two-bank operand store, runs the borrow pass from the low limb
// up into a difference buffer, then emits the magnitude from the top limb.
// ----------------------------------------------------------------------------
module dlbs_back
  import dlbs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  store_wr_t    wr,
  input  job_t         job_in,
  input  jobq_stat_t   qs,
  output logic         pop,
  output back_stat_t   bs,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,   // result_limb
  output logic         out_tuser,   // negative
  output logic         out_tlast    // final_limb
);

  localparam int ST_DEPTH = 2 * (2 ** IDX_W);
  localparam int DB_DEPTH = 2 ** IDX_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_SUB   = 6'b000100,
    S_FLUSH = 6'b001000,
    S_ERD   = 6'b010000,
    S_ELD   = 6'b100000
  } bstate_t;

  logic [LIMB_W-1:0] store_a [ST_DEPTH];
  logic [LIMB_W-1:0] store_b [ST_DEPTH];
  logic [LIMB_W-1:0] diff_buf [DB_DEPTH];

  bstate_t           state_r, state_nxt;
  logic              bank_r, bank_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              asm_r, asm_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic              borrow_r, borrow_nxt;
  logic [LIMB_W:0]   d_r, d_nxt;
  logic [IDX_W-1:0]  kw_r, kw_nxt;
  logic              wpend_r, wpend_nxt;
  logic [IDX_W-1:0]  first_r, first_sel;
  logic              nz_r, nz_sel, nz_clr;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [LIMB_W-1:0] rd_a_r, rd_b_r, db_q_r;
  logic [LIMB_W-1:0] x, y, diff_w;
  logic [LIMB_W:0]   d;
  logic [CNT_W-1:0]  nm1;
  logic              load, is_last;
  logic              ov_r, ov_nxt;
  logic [LIMB_W-1:0] od_r;
  logic              on_r, ol_r;

  // operand store: front end writes, borrow pass reads
  always_ff @(posedge clk) begin
    if (wr.we) begin
      store_a[{wr.bank, wr.idx}] <= wr.a;
      store_b[{wr.bank, wr.idx}] <= wr.b;
    end
    rd_a_r <= store_a[{bank_r, k_r}];
    rd_b_r <= store_b[{bank_r, k_r}];
  end

  always_ff @(posedge clk) begin
    if (wpend_r) begin
      diff_buf[kw_r] <= diff_w;
    end
    db_q_r <= diff_buf[i_r];
  end

  // larger operand is the minuend
  assign x = asm_r ? rd_b_r : rd_a_r;
  assign y = asm_r ? rd_a_r : rd_b_r;
  assign d = {1'b0, x} - {1'b0, y} - (LIMB_W+1)'(borrow_r);

  // borrow taken: add the limb base back
  assign diff_w = d_r[LIMB_W] ? (d_r[LIMB_W-1:0] + LIMB_BASE) : d_r[LIMB_W-1:0];

  // lowest nonzero limb wins since the pass runs downward in index
  assign nz_sel    = nz_r | (wpend_r & (diff_w != '0));
  assign first_sel = (wpend_r && (diff_w != '0)) ? kw_r : first_r;

  assign nm1     = job_in.n - CNT_W'(1);
  assign is_last = !nz_r || ((CNT_W'(i_r) + CNT_W'(1)) == n_r);
  assign load    = (state_r == S_ELD) && (!ov_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    bank_nxt   = bank_r;
    n_nxt      = n_r;
    asm_nxt    = asm_r;
    k_nxt      = k_r;
    borrow_nxt = borrow_r;
    d_nxt      = d_r;
    kw_nxt     = kw_r;
    wpend_nxt  = 1'b0;
    i_nxt      = i_r;
    nz_clr     = 1'b0;
    pop        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!qs.empty) begin
          pop        = 1'b1;
          bank_nxt   = job_in.bank;
          n_nxt      = job_in.n;
          asm_nxt    = job_in.a_small;
          k_nxt      = nm1[IDX_W-1:0];
          borrow_nxt = 1'b0;
          nz_clr     = 1'b1;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_SUB;
      end
      S_SUB: begin
        d_nxt      = d;
        borrow_nxt = d[LIMB_W];
        kw_nxt     = k_r;
        wpend_nxt  = 1'b1;
        if (k_r == '0) begin
          state_nxt = S_FLUSH;
        end else begin
          k_nxt     = k_r - IDX_W'(1);
          state_nxt = S_RD;
        end
      end
      S_FLUSH: begin
        i_nxt     = first_sel;
        state_nxt = S_ERD;
      end
      S_ERD: begin
        state_nxt = S_ELD;
      end
      S_ELD: begin
        if (load) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ov_nxt = load | (ov_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wpend_r <= 1'b0;
      nz_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wpend_r <= wpend_nxt;
      nz_r    <= nz_clr ? 1'b0 : nz_sel;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r   <= bank_nxt;
    n_r      <= n_nxt;
    asm_r    <= asm_nxt;
    k_r      <= k_nxt;
    borrow_r <= borrow_nxt;
    d_r      <= d_nxt;
    kw_r     <= kw_nxt;
    first_r  <= first_sel;
    i_r      <= i_nxt;
    if (load) begin
      od_r <= nz_r ? db_q_r : '0;
      on_r <= nz_r & asm_r;
      ol_r <= is_last;
    end
  end

  assign bs.busy    = (state_r != S_IDLE);
  assign bs.bank    = bank_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = on_r;
  assign out_tlast  = ol_r;

endmodule

>>> hw/rtl/decimal_limb_bignum_subtractor_core.sv
// ----------------------------------------------------------------------------
// decimal_limb_bignum_subtractor_core: |a-b| over base 10^19 limbs, top first
// Load: one limb pair per cycle while a bank is free; the next operand set loads
// while one is at work. After the final pair: dequeue, borrow pass over n limbs
// (store read, then 65-bit subtract), then each result limb is read and output.
// Two store banks, so a third operand set waits until the oldest has loaded its last result limb.
// Synchronous active-low reset clears control state; stores hold no reset value.
// ----------------------------------------------------------------------------
module decimal_limb_bignum_subtractor_core
  import dlbs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,    // limb_a [63:0], limb_b [127:64]
  input  logic         in_tlast,    // final_pair
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,   // result_limb
  output logic         out_tuser,   // negative
  output logic         out_tlast    // final_limb
);

  store_wr_t  wr;
  job_t       job, job_q;
  logic       job_push, job_pop;
  jobq_stat_t qs;
  back_stat_t bs;

  dlbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .qs        (qs),
    .bs        (bs),
    .wr        (wr),
    .job_push  (job_push),
    .job       (job)
  );

  dlbs_job_q u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .job_in  (job),
    .pop     (job_pop),
    .job_out (job_q),
    .qs      (qs)
  );

  dlbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .job_in     (job_q),
    .qs         (qs),
    .pop        (job_pop),
    .bs         (bs),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a finished operand set always finds room in the queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !qs.full)
    else $error("job queue overflow");

  // loading never touches the bank the borrow pass reads
  a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we && bs.busy) |-> (wr.bank != bs.bank))
    else $error("store write into busy bank");

  // every job carries at least one limb
  a_job_len: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (job.n != '0))
    else $error("empty job pushed");

endmodule

>>> verif/decimal_limb_bignum_subtractor_core_test.sv
// ----------------------------------------------------------------------------
// decimal_limb_bignum_subtractor_core_test
// Streams operand sets of base 10^19 limb pairs into the subtractor and
// checks every emitted limb, sign and last flag against a behavioral
// predictor. Runs under several sender/receiver idle mixes, with one long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module decimal_limb_bignum_subtractor_core_test
  import dlbs_pkg::*;
();

  typedef struct packed {
    logic [LIMB_W-1:0] a;
    logic [LIMB_W-1:0] b;
    logic              fin;
  } limb_pair_t;

  typedef struct packed {
    logic [LIMB_W-1:0] limb;
    logic              neg;
    logic              fin;
  } diff_limb_t;

  typedef enum int {GEN_IN_RANGE, GEN_EQUAL, GEN_SHARED_TOP, GEN_EDGE, GEN_RAW} gen_mode_t;

  localparam int HOLD_CYCLES = 600;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // limb_a [63:0], limb_b [127:64]
  logic         in_tlast = 1'b0; // final_pair
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;       // result_limb
  logic         out_tuser;       // negative
  logic         out_tlast;       // final_limb

  decimal_limb_bignum_subtractor_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  limb_pair_t pending_pairs[$];
  diff_limb_t expected_limbs[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int error_count = 0;
  int pairs_queued = 0;
  int pairs_accepted = 0;
  int limbs_checked = 0;
  int sets_queued = 0;
  int overfull_sets = 0;

  // predictor state
  logic [LIMB_W-1:0] model_a [MAX_LIMBS];
  logic [LIMB_W-1:0] model_b [MAX_LIMBS];
  int                model_count = 0;
  logic              model_decided = 1'b0;
  logic              model_a_small = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("decimal_limb_bignum_subtractor_core_test: errors");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic predict_difference(input logic [LIMB_W-1:0] a, input logic [LIMB_W-1:0] b,
                                    input logic fin);
    logic [LIMB_W-1:0] diff [MAX_LIMBS];
    logic [LIMB_W-1:0] x;
    logic [LIMB_W-1:0] y;
    logic              borrow;
    int                lead;
    if (model_count < MAX_LIMBS) begin
      model_a[model_count] = a;
      model_b[model_count] = b;
      model_count++;
      if (!model_decided && a != b) begin
        model_decided = 1'b1;
        model_a_small = a < b;
      end
    end
    if (!fin) return;
    borrow = 1'b0;
    // borrow runs from the least significant limb up, larger operand on top
    for (int k = model_count - 1; k >= 0; k--) begin
      x = model_a_small ? model_b[k] : model_a[k];
      y = model_a_small ? model_a[k] : model_b[k];
      if (x > y || (x == y && !borrow)) begin
        diff[k] = x - y - borrow;
        borrow = 1'b0;
      end else begin
        diff[k] = x + LIMB_BASE - y - borrow;
        borrow = 1'b1;
      end
    end
    lead = 0;
    while (lead < model_count && diff[lead] == '0) lead++;
    if (lead >= model_count) begin
      expected_limbs.push_back('{limb: '0, neg: 1'b0, fin: 1'b1});
    end else begin
      for (int i = lead; i < model_count; i++)
        expected_limbs.push_back('{limb: diff[i], neg: model_a_small, fin: i == model_count - 1});
    end
    model_count = 0;
    model_decided = 1'b0;
    model_a_small = 1'b0;
  endtask

  task automatic compare_output_limb();
    diff_limb_t want;
    limbs_checked++;
    if (expected_limbs.size() == 0) begin
      flag_mismatch($sformatf("limb %h neg %b last %b with nothing expected",
                              out_tdata, out_tuser, out_tlast));
      return;
    end
    want = expected_limbs.pop_front();
    if (out_tdata !== want.limb)
      flag_mismatch($sformatf("result_limb %h, expected %h", out_tdata, want.limb));
    if (out_tuser !== want.neg)
      flag_mismatch($sformatf("negative %b, expected %b (limb %h)", out_tuser, want.neg,
                              want.limb));
    if (out_tlast !== want.fin)
      flag_mismatch($sformatf("final_limb %b, expected %b (limb %h)", out_tlast, want.fin,
                              want.limb));
  endtask

  // driver: a transaction stays offered until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_pairs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {pending_pairs[0].b, pending_pairs[0].a};
        in_tlast  <= pending_pairs[0].fin;
        void'(pending_pairs.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_left != 0 || hold_served != hold_requests)
      out_tready <= 1'b0;
    else
      out_tready <= $urandom_range(99, 0) >= recv_stall_pct;
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_difference(in_tdata[63:0], in_tdata[127:64], in_tlast);
        pairs_accepted++;
      end
      if (out_tvalid && out_tready) compare_output_limb();
    end
  end

  function automatic logic [LIMB_W-1:0] rand_limb();
    return {$urandom, $urandom} % LIMB_BASE;
  endfunction

  function automatic logic [LIMB_W-1:0] boundary_limb();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return 64'd1;
      2: return LIMB_BASE - 1;
      3: return LIMB_BASE - 2;
      4: return 64'($urandom_range(3, 0));
      default: return rand_limb();
    endcase
  endfunction

  task automatic push_pair(input logic [LIMB_W-1:0] a, input logic [LIMB_W-1:0] b,
                           input logic fin);
    pending_pairs.push_back('{a: a, b: b, fin: fin});
    pairs_queued++;
    if (fin) sets_queued++;
  endtask

  // split: pairs above this position are shared by both operands
  task automatic push_operand_set(input int n, input gen_mode_t mode, input int split);
    logic [LIMB_W-1:0] a;
    logic [LIMB_W-1:0] b;
    if (n > MAX_LIMBS) overfull_sets++;
    for (int i = 0; i < n; i++) begin
      case (mode)
        GEN_EQUAL: begin
          a = rand_limb();
          b = a;
        end
        GEN_SHARED_TOP: begin
          a = rand_limb();
          if (i < split) b = a;
          else if (i == split) b = a + ($urandom_range(1, 0) ? 64'd1 : -64'd1);
          else b = rand_limb();
        end
        GEN_EDGE: begin
          a = boundary_limb();
          b = boundary_limb();
        end
        GEN_RAW: begin
          a = {$urandom, $urandom};
          b = $urandom_range(1, 0) ? {$urandom, $urandom} : rand_limb();
        end
        default: begin
          a = rand_limb();
          b = rand_limb();
        end
      endcase
      push_pair(a, b, i == n - 1);
    end
  endtask

  task automatic push_random_set();
    int        n;
    gen_mode_t mode;
    n = ($urandom_range(9, 0) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
    case ($urandom_range(9, 0))
      0, 1, 2: mode = GEN_IN_RANGE;
      3:       mode = GEN_EQUAL;
      4, 5, 6: mode = GEN_SHARED_TOP;
      7, 8:    mode = GEN_EDGE;
      default: mode = GEN_RAW;
    endcase
    push_operand_set(n, mode, $urandom_range(n - 1, 0));
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0 || in_tvalid || expected_limbs.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int pair_goal);
    int start;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = pairs_queued;
    while (pairs_queued - start < pair_goal) push_random_set();
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: single-limb extremes, zero result, sign
    push_pair('0, '0, 1'b1);
    push_pair(LIMB_BASE - 1, '0, 1'b1);
    push_pair('0, LIMB_BASE - 1, 1'b1);
    push_pair(LIMB_BASE - 1, LIMB_BASE - 1, 1'b1);
    // borrow across a limb, leading zero dropped
    push_pair(64'd1, '0, 1'b0);
    push_pair('0, 64'd1, 1'b1);
    push_pair('0, 64'd1, 1'b0);
    push_pair(64'd1, '0, 1'b1);
    // shared top limbs, decided at the bottom
    push_pair(64'd5, 64'd5, 1'b0);
    push_pair(64'd5, 64'd5, 1'b0);
    push_pair(64'd3, 64'd7, 1'b1);
    // longer equal operands give one zero limb
    push_pair(LIMB_BASE - 1, LIMB_BASE - 1, 1'b0);
    push_pair(64'd42, 64'd42, 1'b0);
    push_pair('1, '1, 1'b1);
    // out-of-range limbs used as given
    push_pair('1, '0, 1'b1);
    push_pair('0, '1, 1'b1);
    push_pair(64'd1, '0, 1'b0);
    push_pair('0, '1, 1'b1);
    push_pair('1, 64'd1, 1'b0);
    push_pair(64'h8000_0000_0000_0000, '1, 1'b1);
    drain();

    run_phase(0, 0, 60);
    run_phase(55, 0, 55);
    run_phase(0, 55, 55);
    run_phase(25, 25, 55);

    // receiver holds off while the sender keeps offering; includes full stores
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = hold_requests + 1;
    push_operand_set(MAX_LIMBS, GEN_SHARED_TOP, $urandom_range(MAX_LIMBS - 1, 0));
    push_operand_set(MAX_LIMBS + 3, GEN_SHARED_TOP, MAX_LIMBS + 1);
    repeat (6) push_random_set();
    drain();
    while (hold_left != 0) @(negedge clk);

    run_phase(0, 0, 30);
    repeat (300) @(negedge clk);

    $display("covered %0d operand sets, %0d limb pairs accepted, %0d result limbs checked",
             sets_queued, pairs_accepted, limbs_checked);
    $display("%0d sets overran the limb store; idle mixes 0/55/25 percent plus a long hold-off",
             overfull_sets);
    if (error_count == 0) begin
      $display("decimal_limb_bignum_subtractor_core_test: clean");
    end else begin
      $display("decimal_limb_bignum_subtractor_core_test: errors");
    end
    $finish;
  end

endmodule
